[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[sv/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, operation codes, transaction payloads and control/status bundles.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int CAP_W  = 7;
	localparam int DATA_W = 32;
	localparam int MODE_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] data_value;
	} in_item_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic                     empty_res;
		logic                     full_res;
		logic [CNT_W-1:0]         count;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic read;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

[sv/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// Bounded deque controller
// Sequences one transaction through execute, read and result hand-off.
// ----------------------------------------------------------------------------
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_READ = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.latch    = 1'b0;
		cmd.exec     = 1'b0;
		cmd.read     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/bdq_dpath.sv]
// ----------------------------------------------------------------------------
// Bounded deque datapath
// Ring indices, occupancy, capacity register, entry memory and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_dpath
	import bdq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_item,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_LAST : i - 1'b1;
	endfunction

	logic [MODE_W-1:0]        mode_q;
	logic signed [DATA_W-1:0] data_q;
	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         tail_q;
	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         cap_q;
	logic                     ok_q;
	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_front_q;
	logic signed [DATA_W-1:0] rd_rear_q;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic [CNT_W-1:0] eff_cap;
	logic             full;
	logic             empty;
	logic             ok_d;
	logic             we_d;
	logic [IDX_W-1:0] waddr_d;
	logic [IDX_W-1:0] head_d;
	logic [IDX_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;

	// zero behaves as one, anything beyond the ring behaves as the ring size
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (CNT_W'(cap_q) > CNT_MAX) begin
			eff_cap = CNT_MAX;
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	assign full  = (count_q >= eff_cap);
	assign empty = (count_q == '0);

	always_comb begin
		ok_d    = 1'b1;
		we_d    = 1'b0;
		waddr_d = tail_q;
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		case (mode_q)
			MODE_PUSH_FRONT: begin
				if (full) begin
					ok_d = 1'b0;
				end else begin
					head_d  = ring_prev(head_q);
					waddr_d = ring_prev(head_q);
					we_d    = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					ok_d = 1'b0;
				end else begin
					waddr_d = tail_q;
					tail_d  = ring_next(tail_q);
					we_d    = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					ok_d = 1'b0;
				end else begin
					head_d  = ring_next(head_q);
					count_d = count_q - 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					ok_d = 1'b0;
				end else begin
					tail_d  = ring_prev(tail_q);
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				ok_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			data_q <= in_item.data_value;
		end
		if (cmd.exec) begin
			ok_q <= ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_QUERY;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cmd.latch) begin
				mode_q <= in_item.mode;
			end
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			// drop capacity writes while entries are held
			if (cfg_we && empty) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we_d) begin
			mem[waddr_d] <= data_q;
		end
		if (cmd.read) begin
			rd_front_q <= mem[head_q];
			rd_rear_q  <= mem[ring_prev(tail_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.ok          <= ok_q;
			out_q.front_value <= empty ? -32'sd1 : rd_front_q;
			out_q.rear_value  <= empty ? -32'sd1 : rd_rear_q;
			out_q.empty_res   <= empty;
			out_q.full_res    <= full;
			out_q.count       <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_item        = out_q;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > eff_cap)
	`ASSERT_HOLDS(a_ring_span, clk, arst_n, (tail_q - head_q) == count_q[IDX_W-1:0])
	`ASSERT_HOLDS(a_fail_keeps, clk, arst_n, (cmd.exec && !ok_d) |=> (count_q == $past(count_q)))
	`ASSERT_NEVER(a_load_busy, clk, arst_n, cmd.load_out && out_valid_q && !out_ready)

endmodule

[sv/bounded_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// Flow: an accepted transaction passes through the execute, memory read and result
// load steps of the controller before its result is valid; a new transaction is only
// taken once the result of the last one is loaded, and output back-pressure adds stalls.
// Reset: empty queue, indices zero, capacity 64; entry memory is not cleared.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
	import bdq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	bdq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

[dv/bounded_double_ended_queue_test.sv]
// ----------------------------------------------------------------------------
// Bounded double-ended queue testbench
// Drives push, pop and query transactions with random gaps and output stalls,
// changes the capacity between phases and checks every result against a
// ring-buffer prediction of the queue kept inside the bench.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int SETTLE       = 10;
	localparam int RANDOM_ITEMS = 1450;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	bounded_double_ended_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted queue contents and settings
	logic signed [DATA_W-1:0] deque_slots [DEPTH];
	logic [IDX_W-1:0]         front_idx   = '0;
	logic [IDX_W-1:0]         back_idx    = '0;
	int                       held        = 0;
	logic [CAP_W-1:0]         cap_setting = CAP_RESET;

	in_item_t  pending_ops [$];
	out_item_t expected_status [$];

	int   cycles     = 0;
	int   errors     = 0;
	int   shown      = 0;
	int   idle_left  = 0;
	int   stall_left = 0;
	logic in_taken   = 1'b0;
	logic steady     = 1'b0;

	function automatic logic [IDX_W-1:0] ring_back(input logic [IDX_W-1:0] i);
		return (i == 0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic out_item_t deque_apply(input in_item_t op);
		out_item_t r;
		int        lim;
		logic      full;
		lim = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
		full = (held >= lim);
		r = '0;
		r.ok = 1'b1;
		case (op.mode)
			MODE_PUSH_FRONT: begin
				if (full) begin
					r.ok = 1'b0;
				end else begin
					front_idx = ring_back(front_idx);
					deque_slots[front_idx] = op.data_value;
					held++;
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					r.ok = 1'b0;
				end else begin
					deque_slots[back_idx] = op.data_value;
					back_idx = ring_fwd(back_idx);
					held++;
				end
			end
			MODE_POP_FRONT: begin
				if (held == 0) begin
					r.ok = 1'b0;
				end else begin
					front_idx = ring_fwd(front_idx);
					held--;
				end
			end
			MODE_POP_BACK: begin
				if (held == 0) begin
					r.ok = 1'b0;
				end else begin
					back_idx = ring_back(back_idx);
					held--;
				end
			end
			default: ;
		endcase
		r.front_value = (held != 0) ? deque_slots[front_idx] : -32'sd1;
		r.rear_value  = (held != 0) ? deque_slots[ring_back(back_idx)] : -32'sd1;
		r.empty_res   = (held == 0);
		r.full_res    = (held >= lim);
		r.count       = CNT_W'(held);
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_W-1:0] rand_data();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Driver: new transaction or gap once the previous one has been taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (idle_left > 0) begin
				idle_left--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				in_item   <= pending_ops.pop_front();
				in_valid  <= 1'b1;
				idle_left = steady ? 0 : gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result-side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Monitor: predict on input transactions, check on output transactions
	always @(posedge clk) begin
		out_item_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[bounded_double_ended_queue] ERROR");
			$finish;
		end else if (arst_n) begin
			// A capacity write only takes while the queue is empty
			if (cfg_we && held == 0)
				cap_setting = cfg_wdata;
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_status.push_back(deque_apply(in_item));
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("%0t: result with nothing expected", $realtime);
					end
				end else begin
					want = expected_status.pop_front();
					if (want.ok !== out_item.ok || want.front_value !== out_item.front_value
							|| want.rear_value !== out_item.rear_value
							|| want.empty_res !== out_item.empty_res
							|| want.full_res !== out_item.full_res
							|| want.count !== out_item.count) begin
						errors++;
						if (shown < 10) begin
							shown++;
							$display("%0t: exp ok=%0b front=%0d rear=%0d empty=%0b full=%0b cnt=%0d",
								$realtime, want.ok, want.front_value, want.rear_value,
								want.empty_res, want.full_res, want.count);
							$display("%0t: got ok=%0b front=%0d rear=%0d empty=%0b full=%0b cnt=%0d",
								$realtime, out_item.ok, out_item.front_value,
								out_item.rear_value, out_item.empty_res, out_item.full_res,
								out_item.count);
						end
					end
				end
			end
		end
	end

	task automatic send(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
		in_item_t op;
		op.mode       = mode;
		op.data_value = value;
		pending_ops.push_back(op);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		#1;
		while (pending_ops.size() != 0 || in_valid || expected_status.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int sent;
		int phase_len;
		int push_pct;
		int r;
		logic [CAP_W-1:0] cap_pick;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty queue, value extremes, unused mode codes, index wrap
		send(MODE_QUERY, 32'h1234_5678);
		send(MODE_POP_FRONT, '0);
		send(MODE_POP_BACK, '0);
		send(MODE_PUSH_BACK, 32'h7FFF_FFFF);
		send(MODE_PUSH_FRONT, 32'h8000_0000);
		send(MODE_PUSH_BACK, '1);
		send(3'd5, $urandom);
		send(3'd6, $urandom);
		send(3'd7, $urandom);
		send(MODE_POP_FRONT, '0);
		send(MODE_POP_BACK, '0);
		send(MODE_POP_BACK, '0);
		send(MODE_POP_BACK, '0);
		send(MODE_PUSH_FRONT, '0);
		wait_idle();
		// Ignored: the queue still holds one entry
		write_capacity('0);
		send(MODE_PUSH_BACK, 32'h5555_AAAA);
		send(MODE_POP_FRONT, '0);
		send(MODE_POP_FRONT, '0);
		wait_idle();
		// Zero capacity behaves as one
		write_capacity('0);
		send(MODE_PUSH_BACK, 32'd5);
		send(MODE_PUSH_BACK, 32'd6);
		send(MODE_PUSH_FRONT, 32'd7);
		send(MODE_QUERY, '0);
		send(MODE_POP_FRONT, '0);
		send(MODE_POP_FRONT, '0);
		wait_idle();
		// Above the depth behaves as the depth
		write_capacity('1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady    = ($urandom_range(0, 3) == 0);
			phase_len = ($urandom_range(0, 3) == 0) ? $urandom_range(90, 180)
				: $urandom_range(15, 80);
			push_pct  = $urandom_range(25, 85);
			for (int k = 0; k < phase_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < push_pct)
					send($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, rand_data());
				else if (r < 95)
					send($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, rand_data());
				else if (r < 98)
					send(MODE_QUERY, rand_data());
				else
					send(MODE_W'($urandom_range(5, 7)), rand_data());
			end
			sent += phase_len;
			wait_idle();
			// Drain most of the time so the new capacity takes
			if ($urandom_range(0, 3) != 0) begin
				r = held;
				for (int k = 0; k < r; k++)
					send($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, rand_data());
				sent += r;
				wait_idle();
			end
			case ($urandom_range(0, 7))
				0: cap_pick = '0;
				1: cap_pick = 7'd1;
				2: cap_pick = 7'd2;
				3: cap_pick = CAP_W'(DEPTH);
				4: cap_pick = CAP_W'($urandom_range(DEPTH + 1, 127));
				default: cap_pick = CAP_W'($urandom_range(3, 24));
			endcase
			write_capacity(cap_pick);
		end

		wait_idle();
		if (expected_status.size() != 0)
			errors++;
		if (errors == 0) begin
			$display("[bounded_double_ended_queue] OK");
		end else begin
			$display("[bounded_double_ended_queue] ERROR");
		end
		$finish;
	end

endmodule

[bounded_double_ended_queue.f]
+incdir+sv
sv/bdq_pkg.sv
sv/bdq_ctrl.sv
sv/bdq_dpath.sv
sv/bounded_double_ended_queue.sv
dv/bounded_double_ended_queue_test.sv
